// ===== src/slm_pkg.sv =====
`default_nettype none

package slm_pkg;

  // Field widths of the channels and of the stored window entries.
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 12;
  localparam int REF_W    = 16;
  localparam int VAL_W    = 10;

  // Fixed-point logarithm: five integer bits and sixteen fraction bits.
  localparam int EXP_W    = 5;
  localparam int FRAC_W   = 16;
  localparam int LOG_W    = EXP_W + FRAC_W;
  localparam int MANT_W   = 31;

  // Shared multiplier operand and product widths.
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 64;

  localparam int S_SCALE       = 1000;
  localparam int LOG_SCALE_Q16 = 6313057;
  localparam int LEVEL_MIN     = -2048;
  localparam int LEVEL_MAX     = 2047;

endpackage

`default_nettype wire

// ===== src/slm_ifs.sv =====
`default_nettype none

interface slm_in_if import slm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface slm_out_if import slm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] leq_level;
  logic signed [LEVEL_W-1:0] top_tenth_level;
  logic signed [LEVEL_W-1:0] max_level;

  modport source (output valid, output leq_level, output top_tenth_level,
                  output max_level, input ready);
  modport sink   (input valid, input leq_level, input top_tenth_level,
                  input max_level, output ready);
endinterface

interface slm_cfg_if import slm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REF_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/sound_level_leq_meter.sv =====
`default_nettype none

// Sound level meter giving Leq, L10 and Lmax over a sliding window of group means.
//
// Samples arrive on in_ch, one per transfer. Every GROUP_SIZE transfers the
// truncated group mean enters a ring of WINDOW_DEPTH entries, replacing the
// oldest, and a descending sorted copy of the ring is patched in place. Then
// one result transfer on out_ch carries three levels in signed 1/16 dB.
// cfg_ch writes the zero-dB reference; it is always ready. The reference must be
// written only while the block is idle; the block itself does not enforce this.
// A sample that does not close a group leaves in_ch ready for the next. A closing
// sample keeps in_ch not ready while the group mean is taken by reciprocal
// division, the ring is updated, the sorted copy is patched (over up to
// WINDOW_DEPTH entries), the top TOP_N entries are summed and the three levels
// are converted, each through two logarithms; a level whose sum is zero skips
// its conversion. The sorted-window memory port and the sixteen squarings of each
// logarithm on the single shared multiplier set how long this lasts.
// After reset the block clears both memories, one entry a cycle, over all
// WINDOW_DEPTH entries, and in_ch stays not ready meanwhile.
// A result waits in an output register; samples keep being taken while the
// receiver stalls, and only the next finished group waits for that register.

module sound_level_leq_meter import slm_pkg::*; #(
  parameter int GROUP_SIZE   = 16,
  parameter int WINDOW_DEPTH = 256,
  parameter int TOP_COUNT    = 25
) (
  input wire logic  clk,
  input wire logic  rst_n,
  slm_in_if.sink    in_ch,
  slm_out_if.source out_ch,
  slm_cfg_if.sink   cfg_ch
);

  localparam int TOP_N  = (TOP_COUNT > WINDOW_DEPTH) ? WINDOW_DEPTH : TOP_COUNT;
  localparam int ACC_W  = $clog2(GROUP_SIZE * 1023 + 1);
  localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = $clog2(WINDOW_DEPTH * 1023 + 1);
  localparam int TOP_W  = $clog2(TOP_N * 1023 + 1);
  localparam int MAX_W  = VAL_W + 1;
  localparam int STEP_W = 5;
  // The group mean is the accumulator times a rounded-up reciprocal, shifted
  // down; the extra shift of clog2(GROUP_SIZE) keeps it exact over the
  // whole accumulator range.
  localparam int DIV_SH = ACC_W + $clog2(GROUP_SIZE);
  localparam longint DIV_M = ((longint'(1) << DIV_SH) + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic [17:0] {
    ST_CLR      = 18'h00001,
    ST_IDLE     = 18'h00002,
    ST_DIV      = 18'h00004,
    ST_RING_RD  = 18'h00008,
    ST_RING_WR  = 18'h00010,
    ST_SR_RD    = 18'h00020,
    ST_SR_WR    = 18'h00040,
    ST_TP_RD    = 18'h00080,
    ST_TP_ACC   = 18'h00100,
    ST_LV_BEGIN = 18'h00200,
    ST_LV_MUL   = 18'h00400,
    ST_LG_LOAD  = 18'h00800,
    ST_LG_NORM  = 18'h01000,
    ST_LG_SQ    = 18'h02000,
    ST_LG_SQN   = 18'h04000,
    ST_LV_SCALE = 18'h08000,
    ST_LV_FIN   = 18'h10000,
    ST_DONE     = 18'h20000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [REF_W-1:0]          ref_r, ref_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  logic [VAL_W-1:0]          old_r, old_nxt;
  logic [VAL_W-1:0]          new_r, new_nxt;
  logic                      dir_up_r, dir_up_nxt;
  logic                      active_r, active_nxt;
  logic [VAL_W-1:0]          carry_r, carry_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [TOP_W-1:0]          top_r, top_nxt;
  logic [MAX_W-1:0]          max_r, max_nxt;
  logic [1:0]                lvl_r, lvl_nxt;
  logic                      phase_r, phase_nxt;
  logic [MANT_W-1:0]         x_r, x_nxt;
  logic [EXP_W-1:0]          e_r, e_nxt;
  logic [FRAC_W-1:0]         frac_r, frac_nxt;
  logic [LOG_W-1:0]          l1_r, l1_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [LEVEL_W-1:0] res_r [3];
  logic signed [LEVEL_W-1:0] res_nxt [3];
  logic signed [LEVEL_W-1:0] out_leq_r, out_leq_nxt;
  logic signed [LEVEL_W-1:0] out_top_r, out_top_nxt;
  logic signed [LEVEL_W-1:0] out_max_r, out_max_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Memory ports.
  logic             ring_we, srt_we;
  logic [AW-1:0]    ring_waddr;
  logic [VAL_W-1:0] ring_wdata, srt_wdata;
  logic [VAL_W-1:0] ring_rd, srt_rd;

  // Shared multiplier operands and datapath helpers.
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic                      in_fire;
  logic [ACC_W-1:0]          level_q;
  logic [SUM_W-1:0]          s_sel;
  logic [MUL_W-1:0]          n_sel;
  logic [REF_W-1:0]          ref_eff;
  logic signed [LOG_W:0]     d_log;
  logic [MANT_W:0]           sq_m;
  logic signed [PROD_W-1:0]  q_sum;
  logic signed [MUL_W-1:0]   q32;
  logic signed [LEVEL_W-1:0] q_sat;
  logic                      ins_hit;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign level_q = prod_r[DIV_SH +: ACC_W];
  assign ref_eff = (ref_r == '0) ? REF_W'(1) : ref_r;
  assign d_log   = $signed({1'b0, l1_r}) - $signed({1'b0, e_r, frac_r});
  assign sq_m    = prod_r[2*MANT_W-1:MANT_W-1];
  assign q_sum   = prod_r + 64'sh0000_0000_8000_0000;
  assign q32     = MUL_W'(q_sum >>> 32);
  assign ins_hit = dir_up_r ? (srt_rd < new_r) : (srt_rd > new_r);

  always_comb begin
    if (q32 < LEVEL_MIN) begin
      q_sat = LEVEL_W'(LEVEL_MIN);
    end else if (q32 > LEVEL_MAX) begin
      q_sat = LEVEL_W'(LEVEL_MAX);
    end else begin
      q_sat = LEVEL_W'(q32);
    end
  end

  // The level under conversion and its divisor count.
  always_comb begin
    case (lvl_r)
      2'd0: begin
        s_sel = sum_r;
        n_sel = MUL_W'(WINDOW_DEPTH);
      end
      2'd1: begin
        s_sel = SUM_W'(top_r);
        n_sel = MUL_W'(TOP_N);
      end
      default: begin
        s_sel = SUM_W'(max_r);
        n_sel = MUL_W'(2);
      end
    endcase
  end

  // Operand selection for the one multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_DIV: begin
        mul_a = MUL_W'(acc_r);
        mul_b = MUL_W'(DIV_M);
      end
      ST_LV_MUL: begin
        if (!phase_r) begin
          mul_a = MUL_W'(s_sel);
          mul_b = MUL_W'(S_SCALE);
        end else begin
          mul_a = n_sel;
          mul_b = MUL_W'(ref_eff);
        end
      end
      ST_LG_SQ: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      ST_LV_SCALE: begin
        mul_a = MUL_W'(d_log);
        mul_b = MUL_W'(LOG_SCALE_Q16);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ref_nxt       = ref_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    wp_nxt        = wp_r;
    sum_nxt       = sum_r;
    old_nxt       = old_r;
    new_nxt       = new_r;
    dir_up_nxt    = dir_up_r;
    active_nxt    = active_r;
    carry_nxt     = carry_r;
    idx_nxt       = idx_r;
    top_nxt       = top_r;
    max_nxt       = max_r;
    lvl_nxt       = lvl_r;
    phase_nxt     = phase_r;
    x_nxt         = x_r;
    e_nxt         = e_r;
    frac_nxt      = frac_r;
    l1_nxt        = l1_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_leq_nxt   = out_leq_r;
    out_top_nxt   = out_top_r;
    out_max_nxt   = out_max_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ring_we       = 1'b0;
    srt_we        = 1'b0;
    ring_waddr    = wp_r;
    ring_wdata    = '0;
    srt_wdata     = '0;

    if (cfg_ch.valid) begin
      ref_nxt = cfg_ch.data;
    end

    case (state_r)
      ST_CLR: begin
        ring_we    = 1'b1;
        srt_we     = 1'b1;
        ring_waddr = idx_r;
        if (idx_r == AW'(WINDOW_DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt = acc_r + ACC_W'(in_ch.sample);
          if (cnt_r == CNT_W'(GROUP_SIZE - 1)) begin
            cnt_nxt   = '0;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_DIV: begin
        // The group mean is taken from the bits of this product above DIV_SH.
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_RING_RD;
      end
      ST_RING_RD: begin
        state_nxt = ST_RING_WR;
      end
      ST_RING_WR: begin
        ring_we    = 1'b1;
        ring_wdata = level_q[VAL_W-1:0];
        old_nxt    = ring_rd;
        new_nxt    = level_q[VAL_W-1:0];
        sum_nxt    = sum_r - SUM_W'(ring_rd) + SUM_W'(level_q[VAL_W-1:0]);
        wp_nxt     = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
        acc_nxt    = '0;
        top_nxt    = '0;
        max_nxt    = '0;
        active_nxt = 1'b0;
        dir_up_nxt = level_q[VAL_W-1:0] > ring_rd;
        if (level_q[VAL_W-1:0] == ring_rd) begin
          idx_nxt   = '0;
          state_nxt = ST_TP_RD;
        end else begin
          // A larger value moves towards the head, a smaller one towards the tail.
          idx_nxt   = (level_q[VAL_W-1:0] > ring_rd) ? '0 : AW'(WINDOW_DEPTH - 1);
          state_nxt = ST_SR_RD;
        end
      end
      ST_SR_RD: begin
        state_nxt = ST_SR_WR;
      end
      ST_SR_WR: begin
        if (active_r || ins_hit) begin
          srt_we    = 1'b1;
          srt_wdata = active_r ? carry_r : new_r;
          carry_nxt = srt_rd;
          active_nxt = 1'b1;
        end
        if ((active_r || ins_hit) && srt_rd == old_r) begin
          idx_nxt   = '0;
          state_nxt = ST_TP_RD;
        end else begin
          idx_nxt   = dir_up_r ? idx_r + 1'b1 : idx_r - 1'b1;
          state_nxt = ST_SR_RD;
        end
      end
      ST_TP_RD: begin
        state_nxt = ST_TP_ACC;
      end
      ST_TP_ACC: begin
        top_nxt = top_r + TOP_W'(srt_rd);
        if (idx_r == '0) begin
          max_nxt = MAX_W'(srt_rd);
        end else if (idx_r == AW'(1)) begin
          max_nxt = max_r + MAX_W'(srt_rd);
        end
        if (idx_r == AW'(TOP_N - 1)) begin
          lvl_nxt   = '0;
          state_nxt = ST_LV_BEGIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_TP_RD;
        end
      end
      ST_LV_BEGIN: begin
        if (s_sel == '0) begin
          res_nxt[lvl_r] = LEVEL_W'(LEVEL_MIN);
          if (lvl_r == 2'd2) begin
            state_nxt = ST_DONE;
          end else begin
            lvl_nxt   = lvl_r + 1'b1;
            state_nxt = ST_LV_BEGIN;
          end
        end else begin
          phase_nxt = 1'b0;
          state_nxt = ST_LV_MUL;
        end
      end
      ST_LV_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_LG_LOAD;
      end
      ST_LG_LOAD: begin
        x_nxt     = prod_r[MANT_W-1:0];
        e_nxt     = EXP_W'(MANT_W - 1);
        state_nxt = ST_LG_NORM;
      end
      ST_LG_NORM: begin
        if (x_r[MANT_W-1]) begin
          step_nxt  = '0;
          frac_nxt  = '0;
          state_nxt = ST_LG_SQ;
        end else begin
          x_nxt = {x_r[MANT_W-2:0], 1'b0};
          e_nxt = e_r - 1'b1;
        end
      end
      ST_LG_SQ: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_LG_SQN;
      end
      ST_LG_SQN: begin
        if (sq_m[MANT_W]) begin
          x_nxt    = sq_m[MANT_W:1];
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b1};
        end else begin
          x_nxt    = sq_m[MANT_W-1:0];
          frac_nxt = {frac_r[FRAC_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(FRAC_W - 1)) begin
          if (!phase_r) begin
            l1_nxt    = {e_r, frac_nxt};
            phase_nxt = 1'b1;
            state_nxt = ST_LV_MUL;
          end else begin
            state_nxt = ST_LV_SCALE;
          end
        end else begin
          state_nxt = ST_LG_SQ;
        end
      end
      ST_LV_SCALE: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_LV_FIN;
      end
      ST_LV_FIN: begin
        res_nxt[lvl_r] = q_sat;
        if (lvl_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = ST_LV_BEGIN;
        end
      end
      ST_DONE: begin
        if (!out_valid_r) begin
          out_leq_nxt   = res_r[0];
          out_top_nxt   = res_r[1];
          out_max_nxt   = res_r[2];
          out_valid_nxt = 1'b1;
          lvl_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ref_r       <= REF_W'(1);
      acc_r       <= '0;
      cnt_r       <= '0;
      wp_r        <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      lvl_r       <= '0;
      phase_r     <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      wp_r        <= wp_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      lvl_r       <= lvl_nxt;
      phase_r     <= phase_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    old_r     <= old_nxt;
    new_r     <= new_nxt;
    dir_up_r  <= dir_up_nxt;
    carry_r   <= carry_nxt;
    top_r     <= top_nxt;
    max_r     <= max_nxt;
    x_r       <= x_nxt;
    e_r       <= e_nxt;
    frac_r    <= frac_nxt;
    l1_r      <= l1_nxt;
    prod_r    <= prod_nxt;
    res_r     <= res_nxt;
    out_leq_r <= out_leq_nxt;
    out_top_r <= out_top_nxt;
    out_max_r <= out_max_nxt;
  end

  slm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_addr (wp_r),
    .rd_data (ring_rd)
  );

  slm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_sorted (
    .clk     (clk),
    .wr_en   (srt_we),
    .wr_addr (idx_r),
    .wr_data (srt_wdata),
    .rd_addr (idx_r),
    .rd_data (srt_rd)
  );

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign cfg_ch.ready           = 1'b1;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.leq_level       = out_leq_r;
  assign out_ch.top_tenth_level = out_top_r;
  assign out_ch.max_level       = out_max_r;

  // The closing sample of a group starts the divider.
  a_group_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cnt_r == CNT_W'(GROUP_SIZE - 1) |=> state_r == ST_DIV)
    else $error("group close did not start the divider");

  // A finished result is only loaded into a free output register.
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !out_valid_r |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not loaded into free output register");

  // The write pointer never leaves the ring.
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= AW'(WINDOW_DEPTH - 1))
    else $error("ring write pointer out of range");

endmodule

`default_nettype wire

// ===== src/slm_ram.sv =====
`default_nettype none

module slm_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== test/sound_level_leq_meter_tb.sv =====
`timescale 1ns / 100ps

module sound_level_leq_meter_tb;
  import slm_pkg::*;

  localparam int GROUP     = 16;
  localparam int DEPTH     = 256;
  localparam int TOP_N     = 25;
  localparam longint SCALE = 6313057;

  // The scoreboard holds the meter's own state and the queue of levels still owed.
  typedef struct packed {
    logic signed [LEVEL_W-1:0] leq;
    logic signed [LEVEL_W-1:0] l10;
    logic signed [LEVEL_W-1:0] lmax;
  } levels_t;

  class level_scoreboard;
    bit [15:0] ref_mv;
    bit [15:0] acc;
    int        cnt;
    bit [9:0]  ring [DEPTH];
    bit [9:0]  sorted [DEPTH];
    int        wp;
    bit [17:0] wsum;
    levels_t   owed [$];
    int        fails;

    function new();
      ref_mv = 1; acc = 0; cnt = 0; wp = 0; wsum = 0; fails = 0;
      foreach (ring[i]) begin
        ring[i] = 0;
        sorted[i] = 0;
      end
    endfunction

    // log2 in Q16: integer part from the top set bit, fraction by repeated squaring.
    function longint log2_q16(longint unsigned u);
      int e;
      longint unsigned m;
      longint unsigned frac;
      e = 0;
      frac = 0;
      while (e < 63 && (u >> (e + 1)) != 0) e++;
      if (e <= 30) m = u << (30 - e);
      else m = u >> (e - 30);
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 1;
        end
      end
      return (longint'(e) << 16) | longint'(frac);
    endfunction

    function logic signed [LEVEL_W-1:0] decibels(longint unsigned s, longint unsigned n);
      longint d, p, q;
      longint unsigned r;
      if (s == 0) return LEVEL_W'(LEVEL_MIN);
      r = (ref_mv == 0) ? 1 : ref_mv;
      d = log2_q16(s * 1000) - log2_q16(n * r);
      p = d * SCALE + (64'sd1 << 31);
      q = p >>> 32;
      if (q < LEVEL_MIN) q = LEVEL_MIN;
      if (q > LEVEL_MAX) q = LEVEL_MAX;
      return q[LEVEL_W-1:0];
    endfunction

    function void replace_sorted(bit [9:0] old_v, bit [9:0] new_v);
      int i;
      bit [9:0] t;
      i = 0;
      while (i < DEPTH - 1 && sorted[i] != old_v) i++;
      sorted[i] = new_v;
      while (i > 0 && sorted[i-1] < sorted[i]) begin
        t = sorted[i-1]; sorted[i-1] = sorted[i]; sorted[i] = t; i--;
      end
      while (i < DEPTH - 1 && sorted[i+1] > sorted[i]) begin
        t = sorted[i+1]; sorted[i+1] = sorted[i]; sorted[i] = t; i++;
      end
    endfunction

    // Called for every accepted sample; a group's last sample owes one result.
    function void note_sample(bit [SAMPLE_W-1:0] smp);
      bit [9:0] lvl, old_v;
      longint unsigned top;
      levels_t r;
      acc = acc + smp;
      cnt++;
      if (cnt < GROUP) return;
      lvl = acc / GROUP;
      acc = 0;
      cnt = 0;
      old_v = ring[wp];
      ring[wp] = lvl;
      wsum = wsum - old_v + lvl;
      replace_sorted(old_v, lvl);
      wp = (wp + 1) % DEPTH;
      top = 0;
      for (int i = 0; i < TOP_N; i++) top += sorted[i];
      r.leq  = decibels(wsum, DEPTH);
      r.l10  = decibels(top, TOP_N);
      r.lmax = decibels(longint'(sorted[0]) + sorted[1], 2);
      owed.push_back(r);
    endfunction

    function void check_result(levels_t got);
      levels_t w;
      if (owed.size() == 0) begin
        $error("result transfer with nothing owed");
        fails++;
        return;
      end
      w = owed.pop_front();
      if (got.leq !== w.leq) begin
        $error("leq_level expected %0d actual %0d", w.leq, got.leq);
        fails++;
      end
      if (got.l10 !== w.l10) begin
        $error("top_tenth_level expected %0d actual %0d", w.l10, got.l10);
        fails++;
      end
      if (got.lmax !== w.lmax) begin
        $error("max_level expected %0d actual %0d", w.lmax, got.lmax);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  slm_in_if  in_ch ();
  slm_out_if out_ch ();
  slm_cfg_if cfg_ch ();

  level_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;

  sound_level_leq_meter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready stalls at random, and every transfer is checked on the edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.leq_level, out_ch.top_tenth_level, out_ch.max_level});
    end
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one sample, holding valid until the transfer; the model is told on acceptance.
  // Valid stays high after the transfer until the next sample or an explicit stop.
  task automatic send_sample(input bit [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(smp);
  endtask

  // Waits for the owed results to drain, then for the tail of any group in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  // The register may only change while the meter is idle.
  task automatic write_reference(input bit [REF_W-1:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.ref_mv = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_group(input int lo, input int hi);
    for (int i = 0; i < GROUP; i++) send_sample(SAMPLE_W'($urandom_range(hi, lo)));
  endtask

  initial begin
    int lo;
    int hi;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 77;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a silent group while the window is all zeros, then full scale and extremes.
    for (int i = 0; i < GROUP; i++) send_sample(10'd0);
    send_sample(10'h3FF);
    send_sample(10'h155);
    send_sample(10'h2AA);
    for (int i = 0; i < GROUP - 3; i++) send_sample(10'h3FF);
    write_reference(16'hFFFF);
    send_group(0, 1023);
    write_reference(16'd0);   // a zero reference behaves as one
    send_group(1000, 1023);

    // Random groups in three idling phases and a spread of references.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31; recv_idle_pct = 77;
          write_reference(16'd1);
        end
        1: begin
          send_idle_pct = 77; recv_idle_pct = 31;
          write_reference(16'(1 + $urandom_range(65534)));
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          write_reference(16'd500);
        end
      endcase
      for (int g = 0; g < 14; g++) begin
        case ($urandom_range(3))
          0: begin lo = 0; hi = 3; end
          1: begin lo = 0; hi = 1023; end
          2: begin lo = 1000; hi = 1023; end
          default: begin lo = $urandom_range(1023); hi = lo; end
        endcase
        send_group(lo, hi);
        // Once per phase the sender holds back until every result has come.
        if (g == 7) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (sb.owed.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (sb.fails == 0 && sb.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
